@@ sv/bmd_pkg.sv @@
// Shared types and constants for the banked memory map decoder.
// Holds the request, result and queued command layouts and the memory map sizes.
// No dependencies.
`timescale 1ns / 1ps

package bmd_pkg;

	// Memory map
	localparam int BANK_COUNT          = 16;
	localparam int MODULE_WINDOW_START = 32768;
	localparam int MODULE_WINDOW_SIZE  = 8192;
	localparam int DOS_ROM_START       = 53248;
	localparam int DOS_ROM_SIZE        = 4096;
	localparam int KERNEL_ROM_START    = 57344;

	// Memory depths and address widths
	localparam int RAM_DEPTH  = 65536;
	localparam int RAM_AW     = 16;
	localparam int BANK_DEPTH = BANK_COUNT * MODULE_WINDOW_SIZE;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int BANK_IW    = $clog2(BANK_COUNT);
	localparam int MOD_OW     = $clog2(MODULE_WINDOW_SIZE);
	localparam int DOS_AW     = $clog2(DOS_ROM_SIZE);

	// Post-reset clearing pass covers the deepest memory
	localparam int CLEAR_LEN = (BANK_DEPTH > RAM_DEPTH) ? BANK_DEPTH : RAM_DEPTH;
	localparam int CLR_W     = $clog2(CLEAR_LEN + 1);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QAW         = $clog2(QUEUE_DEPTH);

	// Operation codes
	localparam logic [2:0] OP_BUS_READ   = 3'd0;
	localparam logic [2:0] OP_BUS_WRITE  = 3'd1;
	localparam logic [2:0] OP_RAM_LOAD   = 3'd2;
	localparam logic [2:0] OP_BANK_LOAD  = 3'd3;
	localparam logic [2:0] OP_DOS_LOAD   = 3'd4;
	localparam logic [2:0] OP_DOS_UNLOAD = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  bank_index;
		logic [7:0]  device_read_data;
	} request_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] device_select;
		logic       device_write;
		logic       write_dropped;
		logic [7:0] bank_selected;
		logic       dos_rom_loaded;
	} result_t;

	// Memory action the back end carries out
	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_RAM_RD,
		MEM_RAM_WR,
		MEM_BANK_RD,
		MEM_BANK_WR,
		MEM_DOS_RD,
		MEM_DOS_WR
	} mem_kind_t;

	typedef struct packed {
		mem_kind_t           kind;
		logic [RAM_AW-1:0]   ram_addr;
		logic [BANK_AW-1:0]  bank_addr;
		logic [DOS_AW-1:0]   dos_addr;
		logic [7:0]          wdata;
		result_t             res;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

@@ sv/bmd_ram.sv @@
// Generic simple dual-port RAM with registered read data.
// One write port and one read port; no dependencies.
`timescale 1ns / 1ps

module bmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/bmd_front.sv @@
// Front end: accepts transactions, decodes the memory map and keeps control state.
// Holds the bank register, DOS loaded flag and bank loaded flags. Uses bmd_pkg.
`timescale 1ns / 1ps

module bmd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  bmd_pkg::request_t request,
	input  logic [6:0]        dev_mask,
	input  logic              kernel_protect,
	output logic              push,
	output bmd_pkg::cmd_t     cmd
);
	import bmd_pkg::*;

	localparam logic [15:0] BANK_REG_ADDR = 16'hFE61;

	localparam logic [2:0] DEV_NONE  = 3'd0;
	localparam logic [2:0] DEV_PIA   = 3'd1;
	localparam logic [2:0] DEV_BLOCK = 3'd2;
	localparam logic [2:0] DEV_ACIA  = 3'd3;
	localparam logic [2:0] DEV_VIDEO = 3'd4;
	localparam logic [2:0] DEV_SOUND = 3'd5;
	localparam logic [2:0] DEV_POWER = 3'd6;
	localparam logic [2:0] DEV_CLOCK = 3'd7;

	logic [7:0]            bank_q, bank_d;
	logic                  dos_q, dos_d;
	logic [BANK_COUNT-1:0] loaded_q, loaded_d;

	logic [2:0]  dev;
	logic        wr;
	logic [16:0] mod_diff, dos_diff;
	logic        in_mod, in_dos, bank_ok, kernel_hit;
	logic        load_ok, dos_load_ok;
	logic [BANK_IW-1:0] mul_idx;
	logic [MOD_OW-1:0]  mul_off;
	logic [BANK_AW-1:0] bank_addr;

	function automatic logic in_range(logic [15:0] a, logic [15:0] lo, logic [15:0] hi);
		return (a >= lo) && (a <= hi);
	endfunction

	// I/O page device windows, first attached claimant wins
	function automatic logic [2:0] decode_device(logic [15:0] a, logic [6:0] m);
		if (m[0] && in_range(a, 16'hFE20, 16'hFE23)) return DEV_PIA;
		if (m[1] && in_range(a, 16'hFE24, 16'hFE28)) return DEV_BLOCK;
		if (m[2] && in_range(a, 16'hFE29, 16'hFE2C)) return DEV_ACIA;
		if (m[3] && (in_range(a, 16'hFE2D, 16'hFE37) || in_range(a, 16'hFE62, 16'hFE64)))
			return DEV_VIDEO;
		if (m[4] && in_range(a, 16'hFE38, 16'hFE54)) return DEV_SOUND;
		if (m[5] && a == 16'hFE65) return DEV_POWER;
		if (m[6] && in_range(a, 16'hFE55, 16'hFE60)) return DEV_CLOCK;
		return DEV_NONE;
	endfunction

	assign push = start & ~busy;

	// Window hits and offsets
	always_comb begin
		wr          = (request.op == OP_BUS_WRITE);
		dev         = decode_device(request.address, dev_mask);
		mod_diff    = {1'b0, request.address} - 17'(MODULE_WINDOW_START);
		dos_diff    = {1'b0, request.address} - 17'(DOS_ROM_START);
		in_mod      = ~mod_diff[16] && (mod_diff < 17'(MODULE_WINDOW_SIZE));
		in_dos      = ~dos_diff[16] && (dos_diff < 17'(DOS_ROM_SIZE));
		bank_ok     = ({1'b0, bank_q} < 9'(BANK_COUNT)) && loaded_q[bank_q[BANK_IW-1:0]];
		kernel_hit  = ({1'b0, request.address} >= 17'(KERNEL_ROM_START));
		load_ok     = (request.bank_index != 8'd0)
			&& ({1'b0, request.bank_index} < 9'(BANK_COUNT))
			&& ({1'b0, request.address} < 17'(MODULE_WINDOW_SIZE));
		dos_load_ok = ({1'b0, request.address} < 17'(DOS_ROM_SIZE));
	end

	// One shared bank image address generator
	always_comb begin
		if (request.op == OP_BANK_LOAD) begin
			mul_idx = request.bank_index[BANK_IW-1:0];
			mul_off = request.address[MOD_OW-1:0];
		end else begin
			mul_idx = bank_q[BANK_IW-1:0];
			mul_off = mod_diff[MOD_OW-1:0];
		end
		bank_addr = BANK_AW'(BANK_AW'(mul_idx) * BANK_AW'(MODULE_WINDOW_SIZE)
			+ BANK_AW'(mul_off));
	end

	// Classification in priority order
	always_comb begin
		bank_d   = bank_q;
		dos_d    = dos_q;
		loaded_d = loaded_q;
		cmd          = '0;
		cmd.kind     = MEM_NONE;
		cmd.ram_addr = request.address;
		cmd.wdata    = request.write_data;
		case (request.op)
			OP_BUS_READ, OP_BUS_WRITE: begin
				if (request.address == BANK_REG_ADDR) begin
					if (wr) bank_d = request.write_data;
					else    cmd.res.read_data = bank_q;
				end else if (dev != DEV_NONE) begin
					cmd.res.device_select = dev;
					if (wr) cmd.res.device_write = 1'b1;
					else    cmd.res.read_data = request.device_read_data;
				end else if (dos_q && in_dos) begin
					if (wr) begin
						cmd.res.write_dropped = 1'b1;
					end else begin
						cmd.kind     = MEM_DOS_RD;
						cmd.dos_addr = dos_diff[DOS_AW-1:0];
					end
				end else if (bank_q != 8'd0 && in_mod) begin
					if (wr) begin
						cmd.res.write_dropped = 1'b1;
					end else if (bank_ok) begin
						cmd.kind      = MEM_BANK_RD;
						cmd.bank_addr = bank_addr;
					end
				end else if (wr) begin
					if (kernel_protect && kernel_hit) cmd.res.write_dropped = 1'b1;
					else                              cmd.kind = MEM_RAM_WR;
				end else begin
					cmd.kind = MEM_RAM_RD;
				end
			end
			OP_RAM_LOAD: begin
				cmd.kind = MEM_RAM_WR;
			end
			OP_BANK_LOAD: begin
				if (load_ok) begin
					cmd.kind      = MEM_BANK_WR;
					cmd.bank_addr = bank_addr;
					loaded_d[request.bank_index[BANK_IW-1:0]] = 1'b1;
				end
			end
			OP_DOS_LOAD: begin
				if (dos_load_ok) begin
					cmd.kind     = MEM_DOS_WR;
					cmd.dos_addr = request.address[DOS_AW-1:0];
					dos_d        = 1'b1;
				end
			end
			OP_DOS_UNLOAD: begin
				dos_d = 1'b0;
			end
			default: begin
			end
		endcase
		cmd.res.bank_selected  = bank_d;
		cmd.res.dos_rom_loaded = dos_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= '0;
			dos_q    <= 1'b0;
			loaded_q <= '0;
		end else if (push) begin
			bank_q   <= bank_d;
			dos_q    <= dos_d;
			loaded_q <= loaded_d;
		end
	end

endmodule

@@ sv/bmd_queue.sv @@
// Short command queue decoupling the decode front end from the memory back end.
// Uses bmd_pkg for the command layout and depth.
`timescale 1ns / 1ps

module bmd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bmd_pkg::cmd_t        push_cmd,
	input  logic                 pop,
	output bmd_pkg::cmd_t        head,
	output bmd_pkg::queue_stat_t stat
);
	import bmd_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QAW-1:0]    wptr_q, rptr_q;
	logic [QAW:0]      count_q;

	assign head       = entry_q[rptr_q];
	assign stat.full  = (count_q == (QAW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/bmd_back.sv @@
// Back end: clears the memories after reset, then carries out queued commands.
// Owns main RAM, bank ROM store and DOS ROM store. Uses bmd_pkg and bmd_ram.
`timescale 1ns / 1ps

module bmd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmd_pkg::cmd_t        head,
	input  bmd_pkg::queue_stat_t q_stat,
	output logic                 pop,
	output bmd_pkg::back_stat_t  stat,
	output logic                 done,
	output bmd_pkg::result_t     result
);
	import bmd_pkg::*;

	logic             clearing_q;
	logic [CLR_W-1:0] clr_cnt_q;

	logic               ram_we, bank_we, dos_we;
	logic [RAM_AW-1:0]  ram_waddr;
	logic [BANK_AW-1:0] bank_waddr;
	logic [DOS_AW-1:0]  dos_waddr;
	logic [7:0]         wdata;
	logic [7:0]         ram_rdata, bank_rdata, dos_rdata;

	mem_kind_t kind_s1;
	result_t   res_s1;
	logic      valid_s1;

	assign pop           = ~q_stat.empty & ~clearing_q;
	assign stat.clearing = clearing_q;

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_W'(CLEAR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Write port steering: clearing pass or queued command
	always_comb begin
		if (clearing_q) begin
			ram_we     = (clr_cnt_q < CLR_W'(RAM_DEPTH));
			bank_we    = (clr_cnt_q < CLR_W'(BANK_DEPTH));
			dos_we     = (clr_cnt_q < CLR_W'(DOS_ROM_SIZE));
			ram_waddr  = clr_cnt_q[RAM_AW-1:0];
			bank_waddr = clr_cnt_q[BANK_AW-1:0];
			dos_waddr  = clr_cnt_q[DOS_AW-1:0];
			wdata      = 8'h00;
		end else begin
			ram_we     = pop && (head.kind == MEM_RAM_WR);
			bank_we    = pop && (head.kind == MEM_BANK_WR);
			dos_we     = pop && (head.kind == MEM_DOS_WR);
			ram_waddr  = head.ram_addr;
			bank_waddr = head.bank_addr;
			dos_waddr  = head.dos_addr;
			wdata      = head.wdata;
		end
	end

	bmd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_main_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata),
		.raddr (head.ram_addr),
		.rdata (ram_rdata)
	);

	bmd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_rom (
		.clk   (clk),
		.we    (bank_we),
		.waddr (bank_waddr),
		.wdata (wdata),
		.raddr (head.bank_addr),
		.rdata (bank_rdata)
	);

	bmd_ram #(.WIDTH(8), .DEPTH(DOS_ROM_SIZE)) u_dos_rom (
		.clk   (clk),
		.we    (dos_we),
		.waddr (dos_waddr),
		.wdata (wdata),
		.raddr (head.dos_addr),
		.rdata (dos_rdata)
	);

	// Stage 1: command waits for its registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= head.kind;
			res_s1  <= head.res;
		end
	end

	// Result assembly
	always_comb begin
		result = res_s1;
		case (kind_s1)
			MEM_RAM_RD:  result.read_data = ram_rdata;
			MEM_BANK_RD: result.read_data = bank_rdata;
			MEM_DOS_RD:  result.read_data = dos_rdata;
			default:     result.read_data = res_s1.read_data;
		endcase
	end

	assign done = valid_s1;

endmodule

@@ sv/banked_memory_map_decoder_unit.sv @@
// Top level of the banked memory map decoder: configuration registers and wiring.
// Depends on bmd_pkg, bmd_front, bmd_queue, bmd_back (and bmd_ram through bmd_back).
`timescale 1ns / 1ps

// One transaction is accepted per clock while busy is low; its result appears on
// result with done high for exactly one cycle, after the command has passed through
// the command queue and then the registered memory read. The receiver cannot stall,
// so the back end drains one command every cycle while one is queued, and the queue
// never fills in steady operation. After reset busy stays high for a clearing pass
// over max(65536, BANK_COUNT * MODULE_WINDOW_SIZE) addresses (131072 as configured)
// while the RAM and ROM stores are zeroed one entry per cycle; configuration
// writes are taken during that time. Registers: device_present_mask at 0x0,
// kernel_rom_protect at 0x4; write only while no transaction is in flight.
module banked_memory_map_decoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bmd_pkg::request_t request,
	output logic              done,
	output bmd_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import bmd_pkg::*;

	localparam logic CFG_IDX_MASK    = 1'b0;
	localparam logic CFG_IDX_PROTECT = 1'b1;

	logic [6:0]  dev_mask_q;
	logic        protect_q;
	logic        cfg_wr;

	logic        push, pop;
	cmd_t        push_cmd, head;
	queue_stat_t q_stat;
	back_stat_t  b_stat;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_mask_q <= '0;
			protect_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				CFG_IDX_MASK:    dev_mask_q <= pwdata[6:0];
				CFG_IDX_PROTECT: protect_q  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_IDX_MASK:    prdata = {25'd0, dev_mask_q};
			CFG_IDX_PROTECT: prdata = {31'd0, protect_q};
			default:         prdata = '0;
		endcase
	end

	assign busy = q_stat.full | b_stat.clearing;

	bmd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.dev_mask       (dev_mask_q),
		.kernel_protect (protect_q),
		.push           (push),
		.cmd            (push_cmd)
	);

	bmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	bmd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.stat   (b_stat),
		.done   (done),
		.result (result)
	);

endmodule

@@ bench/bmd_decode_checker.sv @@
// Scoreboard for the banked memory map decoder: follows register writes and accepted
// transactions, keeps its own copy of the memory map and compares every result.
// Depends on bmd_pkg.
`timescale 1ns / 1ps

module bmd_decode_checker #(
	parameter logic [2:0]  MASK_REG_ADDR    = 3'h0,
	parameter logic [2:0]  PROTECT_REG_ADDR = 3'h4,
	parameter logic [15:0] BANK_REG_ADDR    = 16'hFE61
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  bmd_pkg::request_t request,
	input  logic              done,
	input  bmd_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                pending,
	output int                fail_count
);
	import bmd_pkg::*;

	typedef enum logic [2:0] {
		DEV_NONE,
		DEV_PIA,
		DEV_BLOCK,
		DEV_ACIA,
		DEV_VIDEO,
		DEV_SOUND,
		DEV_POWER,
		DEV_CLOCK
	} device_t;

	// Shadow of the memory map; every store comes up zeroed
	bit [7:0] ram_image  [RAM_DEPTH];
	bit [7:0] bank_image [BANK_DEPTH];
	bit       bank_valid [BANK_COUNT];
	bit [7:0] dos_image  [DOS_ROM_SIZE];
	bit       dos_valid;
	bit [7:0] bank_sel;
	bit [6:0] dev_mask;
	bit       kern_protect;

	result_t decodes_due[$];
	int      result_idx;

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("transaction %0d %s: got %0h, expected %0h",
				result_idx, name, got, want));
	endtask

	function automatic bit in_span(input logic [15:0] a, input int unsigned lo,
			input int unsigned hi);
		return a >= lo && a <= hi;
	endfunction

	// I/O page decode, first attached device in priority order wins
	function automatic device_t device_for(input logic [15:0] a);
		if (dev_mask[0] && in_span(a, 'hFE20, 'hFE23)) return DEV_PIA;
		if (dev_mask[1] && in_span(a, 'hFE24, 'hFE28)) return DEV_BLOCK;
		if (dev_mask[2] && in_span(a, 'hFE29, 'hFE2C)) return DEV_ACIA;
		if (dev_mask[3] && (in_span(a, 'hFE2D, 'hFE37) || in_span(a, 'hFE62, 'hFE64)))
			return DEV_VIDEO;
		if (dev_mask[4] && in_span(a, 'hFE38, 'hFE54)) return DEV_SOUND;
		if (dev_mask[5] && a == 16'hFE65) return DEV_POWER;
		if (dev_mask[6] && in_span(a, 'hFE55, 'hFE60)) return DEV_CLOCK;
		return DEV_NONE;
	endfunction

	// Decode one transaction against the shadow map and update it
	function automatic result_t decode_access(input request_t r);
		result_t     res;
		int unsigned addr;
		device_t     dev;
		bit          wr;
		res  = '0;
		addr = r.address;
		wr   = (r.op == OP_BUS_WRITE);
		case (r.op)
			OP_BUS_READ, OP_BUS_WRITE: begin
				dev = device_for(r.address);
				if (r.address == BANK_REG_ADDR) begin
					if (wr) bank_sel = r.write_data;
					else    res.read_data = bank_sel;
				end else if (dev != DEV_NONE) begin
					res.device_select = dev;
					if (wr) res.device_write = 1'b1;
					else    res.read_data = r.device_read_data;
				end else if (dos_valid && addr >= DOS_ROM_START &&
						addr < DOS_ROM_START + DOS_ROM_SIZE) begin
					if (wr) res.write_dropped = 1'b1;
					else    res.read_data = dos_image[addr - DOS_ROM_START];
				end else if (bank_sel != 0 && addr >= MODULE_WINDOW_START &&
						addr < MODULE_WINDOW_START + MODULE_WINDOW_SIZE) begin
					// unloaded or out-of-range banks read as zero
					if (wr)
						res.write_dropped = 1'b1;
					else if (bank_sel < BANK_COUNT && bank_valid[bank_sel])
						res.read_data = bank_image[bank_sel * MODULE_WINDOW_SIZE +
							addr - MODULE_WINDOW_START];
				end else if (wr) begin
					if (kern_protect && addr >= KERNEL_ROM_START)
						res.write_dropped = 1'b1;
					else
						ram_image[addr] = r.write_data;
				end else begin
					res.read_data = ram_image[addr];
				end
			end
			OP_RAM_LOAD: ram_image[addr] = r.write_data;
			OP_BANK_LOAD: begin
				if (r.bank_index != 0 && r.bank_index < BANK_COUNT &&
						addr < MODULE_WINDOW_SIZE) begin
					bank_image[r.bank_index * MODULE_WINDOW_SIZE + addr] = r.write_data;
					bank_valid[r.bank_index] = 1'b1;
				end
			end
			OP_DOS_LOAD: begin
				if (addr < DOS_ROM_SIZE) begin
					dos_image[addr] = r.write_data;
					dos_valid = 1'b1;
				end
			end
			OP_DOS_UNLOAD: dos_valid = 1'b0;
			default: ;
		endcase
		res.bank_selected  = bank_sel;
		res.dos_rom_loaded = dos_valid;
		return res;
	endfunction

	// Register writes, result comparison, then the newly accepted transaction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			decodes_due.delete();
			dos_valid    = 1'b0;
			bank_sel     = '0;
			dev_mask     = '0;
			kern_protect = 1'b0;
			result_idx   = 0;
			for (int i = 0; i < BANK_COUNT; i++)
				bank_valid[i] = 1'b0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == MASK_REG_ADDR)
					dev_mask = pwdata[6:0];
				else if (paddr == PROTECT_REG_ADDR)
					kern_protect = pwdata[0];
			end
			if (done) begin
				if (decodes_due.size() == 0) begin
					report_mismatch("result strobe with no transaction outstanding");
				end else begin
					want = decodes_due.pop_front();
					check_field("read_data", result.read_data, want.read_data);
					check_field("device_select", result.device_select, want.device_select);
					check_field("device_write", result.device_write, want.device_write);
					check_field("write_dropped", result.write_dropped, want.write_dropped);
					check_field("bank_selected", result.bank_selected, want.bank_selected);
					check_field("dos_rom_loaded", result.dos_rom_loaded,
						want.dos_rom_loaded);
				end
				result_idx++;
			end
			if (start && !busy)
				decodes_due.push_back(decode_access(request));
			pending <= decodes_due.size();
		end
	end

endmodule

@@ bench/tb_banked_memory_map_decoder_unit.sv @@
// Top of the decoder testbench: clock, reset, register writes and bus transactions.
// Depends on bmd_pkg, banked_memory_map_decoder_unit and bmd_decode_checker.
`timescale 1ns / 1ps

module tb_banked_memory_map_decoder_unit;
	import bmd_pkg::*;

	localparam logic [2:0]  REG_DEVICE_MASK    = 3'h0;
	localparam logic [2:0]  REG_KERNEL_PROTECT = 3'h4;
	localparam logic [15:0] BANK_REG_ADDR      = 16'hFE61;
	localparam logic [15:0] IO_PAGE_LO         = 16'hFE20;
	localparam logic [2:0]  OP_SPARE_LO        = 3'd6;
	localparam logic [2:0]  OP_SPARE_HI        = 3'd7;
	localparam logic [6:0]  ALL_DEVICES        = 7'h7F;
	localparam int          PHASE_ITEMS        = 130;
	localparam int          SETTLE_CYCLES      = 4;
	// clearing pass plus a few hundred transactions, taken several times over
	localparam int unsigned CYCLE_LIMIT        = 600000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	request_t    request;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          pending;
	int          fail_count;
	int unsigned cycle_count = 0;
	int          sent;
	logic [6:0]  mask_val;
	logic        prot_val;

	always #5 clk = ~clk;

	banked_memory_map_decoder_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bmd_decode_checker #(
		.MASK_REG_ADDR    (REG_DEVICE_MASK),
		.PROTECT_REG_ADDR (REG_KERNEL_PROTECT),
		.BANK_REG_ADDR    (BANK_REG_ADDR)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Setup then access phase; the write lands at the edge ending the access phase,
	// after which the port is left idle before the task returns
	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Holds start high until the transaction is taken; start stays high on return
	task automatic send_item(input request_t r);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	// Drain every outstanding result, then let the pipeline go quiet
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic request_t make_access(input logic [2:0] op, input logic [15:0] addr,
			input logic [7:0] wd, input logic [7:0] bidx, input logic [7:0] drd);
		request_t r;
		r.op               = op;
		r.address          = addr;
		r.write_data       = wd;
		r.bank_index       = bidx;
		r.device_read_data = drd;
		return r;
	endfunction

	// Offset near either end of a window, so loads and reads keep meeting
	function automatic int unsigned hot_offset(input int unsigned span);
		if ($urandom_range(0, 1))
			return $urandom_range(0, 15);
		return span - 16 + $urandom_range(0, 15);
	endfunction

	function automatic logic [15:0] pick_address();
		int unsigned a;
		case ($urandom_range(0, 8))
			0: a = IO_PAGE_LO + $urandom_range(0, 'h46);
			1: a = BANK_REG_ADDR;
			2: a = MODULE_WINDOW_START + hot_offset(MODULE_WINDOW_SIZE);
			3: a = DOS_ROM_START + hot_offset(DOS_ROM_SIZE);
			4: a = KERNEL_ROM_START + hot_offset(RAM_DEPTH - KERNEL_ROM_START);
			5: a = $urandom_range(0, 15);
			6: a = $urandom;
			7: a = ($urandom_range(0, 1) ? MODULE_WINDOW_START :
				MODULE_WINDOW_START + MODULE_WINDOW_SIZE) - 8 + $urandom_range(0, 15);
			default: a = ($urandom_range(0, 1) ? DOS_ROM_START :
				DOS_ROM_START + DOS_ROM_SIZE) - 8 + $urandom_range(0, 15);
		endcase
		return a[15:0];
	endfunction

	// Mostly loadable banks, sometimes zero or past the last bank
	function automatic logic [7:0] pick_bank();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			5: return 8'($urandom_range(BANK_COUNT, 255));
			default: return 8'($urandom_range(1, BANK_COUNT - 1));
		endcase
	endfunction

	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		r    = make_access(OP_BUS_READ, pick_address(), 8'($urandom), 8'($urandom),
			8'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.op = OP_BUS_READ;
		end else if (pick < 58) begin
			r.op = OP_BUS_WRITE;
			if ($urandom_range(0, 4) == 0) begin
				r.address    = BANK_REG_ADDR;
				r.write_data = pick_bank();
			end
		end else if (pick < 66) begin
			r.op = OP_RAM_LOAD;
		end else if (pick < 80) begin
			r.op = OP_BANK_LOAD;
			r.bank_index = ($urandom_range(0, 9) == 0) ? pick_bank() :
				8'($urandom_range(1, BANK_COUNT - 1));
			r.address = ($urandom_range(0, 9) == 0) ?
				16'($urandom_range(MODULE_WINDOW_SIZE, 65535)) :
				16'(hot_offset(MODULE_WINDOW_SIZE));
		end else if (pick < 90) begin
			r.op = OP_DOS_LOAD;
			r.address = ($urandom_range(0, 9) == 0) ?
				16'($urandom_range(DOS_ROM_SIZE, 65535)) : 16'(hot_offset(DOS_ROM_SIZE));
		end else if (pick < 94) begin
			r.op = OP_DOS_UNLOAD;
		end else begin
			r.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
		end
		return r;
	endfunction

	initial begin
		start   <= 1'b0;
		request <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		arst_n  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every device attached, kernel area protected
		cfg_write(REG_DEVICE_MASK, 32'(ALL_DEVICES));
		cfg_write(REG_KERNEL_PROTECT, 32'd1);
		send_item(make_access(OP_BUS_READ, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_item(make_access(OP_RAM_LOAD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_access(OP_BUS_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_WRITE, 16'(KERNEL_ROM_START), 8'h5A, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, IO_PAGE_LO, 8'h00, 8'h00, 8'h5A));
		send_item(make_access(OP_BUS_READ, 16'hFE65, 8'h00, 8'h00, 8'hA5));
		send_item(make_access(OP_BUS_WRITE, 16'hFE64, 8'h77, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, 16'hFE60, 8'h00, 8'h00, 8'hFF));
		// out-of-range DOS offset must not mark the image loaded
		send_item(make_access(OP_DOS_LOAD, 16'hFFFF, 8'h11, 8'h00, 8'h00));
		send_item(make_access(OP_DOS_LOAD, 16'h0000, 8'h3C, 8'h00, 8'h00));
		send_item(make_access(OP_DOS_LOAD, 16'(DOS_ROM_SIZE - 1), 8'hC3, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, 16'(DOS_ROM_START + DOS_ROM_SIZE - 1), 8'h00,
			8'h00, 8'h00));
		send_item(make_access(OP_BUS_WRITE, 16'(DOS_ROM_START), 8'h99, 8'h00, 8'h00));
		send_item(make_access(OP_DOS_UNLOAD, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, 16'(DOS_ROM_START), 8'h00, 8'h00, 8'h00));
		// bank zero, bank past the end and offset past the window are all ignored
		send_item(make_access(OP_BANK_LOAD, 16'h0000, 8'h42, 8'h00, 8'h00));
		send_item(make_access(OP_BANK_LOAD, 16'h0000, 8'h42, 8'(BANK_COUNT), 8'h00));
		send_item(make_access(OP_BANK_LOAD, 16'(MODULE_WINDOW_SIZE), 8'h42, 8'h01, 8'h00));
		send_item(make_access(OP_BANK_LOAD, 16'(MODULE_WINDOW_SIZE - 1), 8'h81,
			8'(BANK_COUNT - 1), 8'h00));
		send_item(make_access(OP_BUS_WRITE, BANK_REG_ADDR, 8'(BANK_COUNT - 1), 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, 16'(MODULE_WINDOW_START + MODULE_WINDOW_SIZE - 1),
			8'h00, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_WRITE, 16'(MODULE_WINDOW_START), 8'h24, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_WRITE, BANK_REG_ADDR, 8'hFF, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, 16'(MODULE_WINDOW_START), 8'h00, 8'h00, 8'h00));
		// bank one was never loaded
		send_item(make_access(OP_BUS_WRITE, BANK_REG_ADDR, 8'h01, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_READ, 16'(MODULE_WINDOW_START), 8'h00, 8'h00, 8'h00));
		send_item(make_access(OP_BUS_WRITE, BANK_REG_ADDR, 8'h00, 8'h00, 8'h00));
		send_item(make_access(OP_SPARE_LO, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_access(OP_SPARE_HI, 16'h0000, 8'h00, 8'h00, 8'h00));

		// Random phases, each under its own register settings
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			case (phase)
				0: begin mask_val = '0; prot_val = 1'b0; end
				1: begin mask_val = ALL_DEVICES; prot_val = 1'b0; end
				2: begin mask_val = 7'($urandom); prot_val = 1'b1; end
				3: begin mask_val = 7'($urandom); prot_val = 1'($urandom); end
				default: begin mask_val = ALL_DEVICES; prot_val = 1'b1; end
			endcase
			cfg_write(REG_DEVICE_MASK, 32'(mask_val));
			cfg_write(REG_KERNEL_PROTECT, 32'(prot_val));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				repeat ($urandom_range(1, 24)) begin
					send_item(random_request());
					sent++;
				end
				// bursts sometimes run straight into each other
				if ($urandom_range(0, 3) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 5)) @(posedge clk);
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
sv/bmd_pkg.sv
sv/bmd_ram.sv
sv/bmd_front.sv
sv/bmd_queue.sv
sv/bmd_back.sv
sv/banked_memory_map_decoder_unit.sv
bench/bmd_decode_checker.sv
bench/tb_banked_memory_map_decoder_unit.sv
